/* rtl/mpbb_pkg.sv */
// mpbb_pkg: types, constants and helpers for the batch-blocked max pool block
// no dependencies
package mpbb_pkg;

	localparam int LANES_DEF = 24;
	localparam int MAX_FEATURES_DEF = 16;
	localparam int MAX_OUT_COLS_DEF = 64;
	localparam int OPEN_ROW_SLOTS_DEF = 4;
	localparam int MAX_WINDOW = 4;

	typedef enum logic [2:0] {
		REG_WINDOW_WIDTH  = 3'd0,
		REG_WINDOW_HEIGHT = 3'd1,
		REG_STRIDE_X      = 3'd2,
		REG_STRIDE_Y      = 3'd3,
		REG_FIRST_OUT_ROW = 3'd4,
		REG_FIRST_OUT_COL = 3'd5,
		REG_OUT_ROWS      = 3'd6,
		REG_OUT_COLS      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  batch_group;
		logic [11:0] in_row;
		logic [11:0] in_col;
		logic [3:0]  feature_index;
		logic [4:0]  lane_index;
		logic [31:0] sample_value;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  out_batch_group;
		logic [12:0] out_row;
		logic [12:0] out_col;
		logic [3:0]  out_feature;
		logic [4:0]  out_lane;
		logic [31:0] max_value;
	} out_word_t;

	typedef struct packed {
		logic [2:0]  ww;
		logic [2:0]  wh;
		logic [2:0]  sx;
		logic [2:0]  sy;
		logic [11:0] first_row;
		logic [11:0] first_col;
		logic [12:0] rows;
		logic [10:0] cols;
	} cfg_t;

	function automatic logic [2:0] clamp_dim(input logic [2:0] v);
		logic [2:0] r;
		r = v;
		if (v == 3'd0) r = 3'd1;
		else if (v > 3'd4) r = 3'd4;
		return r;
	endfunction

	// quotient by a stride of one to four; three by reciprocal multiply
	function automatic logic [11:0] div_small(input logic [11:0] v, input logic [2:0] d);
		logic [23:0] p;
		logic [11:0] q;
		p = 24'(v) * 24'd2731;
		q = v;
		unique case (d)
			3'd2: q = v >> 1;
			3'd3: q = 12'(p[23:13]);
			3'd4: q = v >> 2;
			default: q = v;
		endcase
		return q;
	endfunction

	function automatic logic is_nan(input logic [31:0] a);
		return a[30:0] > 31'h7f800000;
	endfunction

	function automatic logic [31:0] order_key(input logic [31:0] a);
		return a[31] ? ~a : (a | 32'h80000000);
	endfunction

	function automatic logic greater_bits(input logic [31:0] a, input logic [31:0] b);
		logic g;
		g = 1'b0;
		if (!is_nan(a) && !is_nan(b) && ((a[30:0] | b[30:0]) != 31'd0))
			g = order_key(a) > order_key(b);
		return g;
	endfunction

endpackage

/* rtl/mpbb_cfg.sv */
// mpbb_cfg: configuration registers with clamping of window, stride and width
// depends on mpbb_pkg
module mpbb_cfg #(
	parameter int MAX_OUT_COLS = mpbb_pkg::MAX_OUT_COLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [2:0]        wr_idx,
	input  logic [12:0]       wr_data,
	output mpbb_pkg::cfg_t    cfg
);
	import mpbb_pkg::*;

	logic [2:0]  ww_q, wh_q, sx_q, sy_q;
	logic [11:0] frow_q, fcol_q;
	logic [12:0] rows_q;
	logic [6:0]  cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ww_q <= 3'd2; wh_q <= 3'd2; sx_q <= 3'd2; sy_q <= 3'd2;
			frow_q <= '0; fcol_q <= '0; rows_q <= 13'd1; cols_q <= 7'd1;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_idx))
				REG_WINDOW_WIDTH:  ww_q <= wr_data[2:0];
				REG_WINDOW_HEIGHT: wh_q <= wr_data[2:0];
				REG_STRIDE_X:      sx_q <= wr_data[2:0];
				REG_STRIDE_Y:      sy_q <= wr_data[2:0];
				REG_FIRST_OUT_ROW: frow_q <= wr_data[11:0];
				REG_FIRST_OUT_COL: fcol_q <= wr_data[11:0];
				REG_OUT_ROWS:      rows_q <= wr_data;
				REG_OUT_COLS:      cols_q <= wr_data[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.ww = clamp_dim(ww_q);
		cfg.wh = clamp_dim(wh_q);
		cfg.sx = clamp_dim(sx_q);
		cfg.sy = clamp_dim(sy_q);
		cfg.first_row = frow_q;
		cfg.first_col = fcol_q;
		cfg.rows = rows_q;
		cfg.cols = (32'(cols_q) > MAX_OUT_COLS) ? 11'(MAX_OUT_COLS) : 11'(cols_q);
	end
endmodule

/* rtl/mpbb_store.sv */
// mpbb_store: partial maximum memory, one write and one registered read port
// depends on mpbb_pkg
module mpbb_store #(
	parameter int DEPTH = 98304,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data
);
	import mpbb_pkg::*;

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem[rd_addr];
	end
endmodule

/* rtl/max_pool_2d_batch_block.sv */
// max_pool_2d_batch_block: top level, window sequencer and read-modify-write
// depends on mpbb_pkg, mpbb_cfg, mpbb_store
//
// channel   dir  handshake                payload
// in        in   in_valid / in_ready      in_word (mpbb_pkg::in_word_t)
// out       out  out_valid / out_ready    out_word (mpbb_pkg::out_word_t)
// cfg       in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// one sample passes the accept state (ST_IDLE) and the divide state (ST_DIV), then
// a read (ST_CAND) and a write (ST_WRITE) per window candidate (up to 16), set by
// the single read port of the store; a skipped row or the end of the scan takes only ST_CAND, then ST_OUT with a result
// no clearing after reset; entries are loaded by the window's first sample
// a held result lets the next sample run; it waits to post its own word
module max_pool_2d_batch_block #(
	parameter int LANES = mpbb_pkg::LANES_DEF,
	parameter int MAX_FEATURES = mpbb_pkg::MAX_FEATURES_DEF,
	parameter int MAX_OUT_COLS = mpbb_pkg::MAX_OUT_COLS_DEF,
	parameter int OPEN_ROW_SLOTS = mpbb_pkg::OPEN_ROW_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mpbb_pkg::in_word_t   in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mpbb_pkg::out_word_t  out_word,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [12:0]          cfg_data
);
	import mpbb_pkg::*;

	localparam int DEPTH = OPEN_ROW_SLOTS * MAX_OUT_COLS * MAX_FEATURES * LANES;
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_CAND  = 5'b00100,
		ST_WRITE = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q;
	cfg_t cfg;
	in_word_t w_q;
	logic [11:0] rbase_q, cbase_q;
	logic [1:0] kr_q, kc_q;
	logic produced_q;
	logic [31:0] val_q;
	logic [12:0] r_q, c_q;
	logic first_q, last_q, upd_q;
	logic [AW-1:0] addr_q;
	logic [31:0] rd_data;
	out_word_t res_q;
	out_word_t out_q;
	logic out_valid_q;
	logic post_c;

	mpbb_cfg #(.MAX_OUT_COLS(MAX_OUT_COLS)) u_cfg (
		.clk, .arst_n, .wr_en(cfg_valid && cfg_ready), .wr_idx(cfg_index),
		.wr_data(cfg_data), .cfg(cfg)
	);

	// candidate evaluation
	logic [12:0] r_c, c_c, ci_c;
	logic [13:0] dy_c, dx_c;
	logic rdone_c, cdone_c, rin_c, cin_c;
	logic [AW+8:0] addr_c;
	logic [31:0] slot_c;

	always_comb begin
		r_c = 13'(rbase_q) - 13'(kr_q);
		c_c = 13'(cbase_q) - 13'(kc_q);
		dy_c = 14'(w_q.in_row) - 14'(r_c * 13'(cfg.sy));
		dx_c = 14'(w_q.in_col) - 14'(c_c * 13'(cfg.sx));
		rdone_c = (rbase_q < 12'(kr_q)) || (dy_c >= 14'(cfg.wh));
		cdone_c = (cbase_q < 12'(kc_q)) || (dx_c >= 14'(cfg.ww));
		rin_c = (r_c >= 13'(cfg.first_row)) && ((r_c - 13'(cfg.first_row)) < cfg.rows);
		ci_c = c_c - 13'(cfg.first_col);
		cin_c = (c_c >= 13'(cfg.first_col)) && (ci_c < 13'(cfg.cols));
		slot_c = 32'(r_c) % OPEN_ROW_SLOTS;
		addr_c = (AW+9)'((((slot_c * MAX_OUT_COLS + 32'(ci_c)) * MAX_FEATURES
			+ 32'(w_q.feature_index)) * LANES) + 32'(w_q.lane_index));
	end

	logic wr_en;
	logic [31:0] wr_val;
	always_comb begin
		wr_en = (state_q == ST_WRITE) && upd_q;
		wr_val = (first_q || !greater_bits(rd_data, val_q)) ? val_q : rd_data;
	end

	mpbb_store #(.DEPTH(DEPTH)) u_store (
		.clk, .rd_en(state_q == ST_CAND), .rd_addr(addr_c[AW-1:0]), .rd_data,
		.wr_en, .wr_addr(addr_q), .wr_data(wr_val)
	);

	assign post_c = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_word = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			produced_q <= 1'b0;
			kr_q <= '0;
			kc_q <= '0;
			upd_q <= 1'b0;
		end else begin
			if (post_c) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						produced_q <= 1'b0;
						kr_q <= '0;
						kc_q <= '0;
						state_q <= (32'(in_word.lane_index) < LANES &&
							32'(in_word.feature_index) < MAX_FEATURES) ? ST_DIV : ST_IDLE;
					end
				end
				ST_DIV: state_q <= ST_CAND;
				ST_CAND: begin
					upd_q <= 1'b0;
					if (rdone_c) begin
						state_q <= produced_q ? ST_OUT : ST_IDLE;
					end else if (!rin_c || cdone_c) begin
						kc_q <= '0;
						if (kr_q == 2'(MAX_WINDOW - 1))
							state_q <= produced_q ? ST_OUT : ST_IDLE;
						else kr_q <= kr_q + 2'd1;
					end else begin
						upd_q <= cin_c && (32'(addr_c) < DEPTH);
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (upd_q && last_q && !produced_q) produced_q <= 1'b1;
					if (kc_q == 2'(MAX_WINDOW - 1)) begin
						kc_q <= '0;
						if (kr_q == 2'(MAX_WINDOW - 1))
							state_q <= (produced_q || (upd_q && last_q)) ? ST_OUT : ST_IDLE;
						else begin
							kr_q <= kr_q + 2'd1;
							state_q <= ST_CAND;
						end
					end else begin
						kc_q <= kc_q + 2'd1;
						state_q <= ST_CAND;
					end
				end
				ST_OUT: begin
					if (post_c) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && in_ready) w_q <= in_word;
		if (state_q == ST_DIV) begin
			rbase_q <= div_small(w_q.in_row, cfg.sy);
			cbase_q <= div_small(w_q.in_col, cfg.sx);
			val_q <= w_q.sample_value;
		end
		if (state_q == ST_CAND) begin
			addr_q <= addr_c[AW-1:0];
			r_q <= r_c;
			c_q <= c_c;
			first_q <= (dy_c == 14'd0) && (dx_c == 14'd0);
			last_q <= (dy_c == 14'(cfg.wh) - 14'd1) && (dx_c == 14'(cfg.ww) - 14'd1);
		end
		if (wr_en && last_q && !produced_q) begin
			res_q.out_batch_group <= w_q.batch_group;
			res_q.out_row <= r_q;
			res_q.out_col <= c_q;
			res_q.out_feature <= w_q.feature_index;
			res_q.out_lane <= 5'(w_q.lane_index);
			res_q.max_value <= wr_val;
		end
		if (post_c) out_q <= res_q;
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (state_q == ST_IDLE))
		else $error("sample accepted while busy");
	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> $past(state_q == ST_CAND))
		else $error("store write without read");
	a_out_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside output state");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
		else $error("held result changed");
`endif
endmodule
